// ===== rtl/ste_pkg.sv =====
// ----------------------------------------------------------------------------
// ste_pkg
// Types and constants shared by the sorted table engine.
// ----------------------------------------------------------------------------
package ste_pkg;

  // table geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // result field widths
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  // command codes
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_RES
  } state_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                     cmp;
    logic                     ins;
    logic                     del;
    logic                     clr;
    logic signed [VAL_W-1:0]  value;
  } cell_ctrl_t;

  // what one cell shows its neighbours
  typedef struct packed {
    logic signed [VAL_W-1:0]  val;
    logic                     valid;
    logic                     lt;
  } cell_nb_t;

endpackage

// ===== rtl/ste_if.sv =====
// ----------------------------------------------------------------------------
// ste_cmd_if / ste_res_if
// Valid/ready channels for command requests and result requests.
// ----------------------------------------------------------------------------
interface ste_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       kind;
  logic signed [ste_pkg::VAL_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ste_res_if;
  logic                               valid;
  logic                               ready;
  logic                               ok;
  logic [ste_pkg::POS_W-1:0]          position;
  logic [ste_pkg::COUNT_W-1:0]        count;
  logic signed [ste_pkg::VAL_W-1:0]   smallest;
  logic signed [ste_pkg::VAL_W-1:0]   largest;
  logic                               full_res;

  modport source (output valid, output ok, output position, output count,
                  output smallest, output largest, output full_res, input ready);
  modport sink   (input valid, input ok, input position, input count,
                  input smallest, input largest, input full_res, output ready);
endinterface

// ===== rtl/ste_cell.sv =====
// ----------------------------------------------------------------------------
// ste_cell
// One table slot: holds an entry and its occupancy, compares against the
// broadcast value and shifts with its neighbours on insert and delete.
// ----------------------------------------------------------------------------
module ste_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ste_pkg::cell_ctrl_t ctrl_i,
  input  ste_pkg::cell_nb_t   left_i,
  input  ste_pkg::cell_nb_t   right_i,
  output ste_pkg::cell_nb_t   self_o,
  output logic                first_ge_o,
  output logic                eq_o,
  output logic signed [ste_pkg::VAL_W-1:0] last_val_o
);

  logic signed [ste_pkg::VAL_W-1:0] entry_q, entry_d;
  logic valid_q, valid_d;
  logic lt_q, eq_q;

  // first slot not below the value: insert point, or first match
  assign first_ge_o = !lt_q && left_i.lt;
  assign eq_o       = eq_q;

  // last occupied slot drives the largest entry onto the or-tree
  assign last_val_o = (valid_q && !right_i.valid) ? entry_q : '0;

  assign self_o.val   = entry_q;
  assign self_o.valid = valid_q;
  assign self_o.lt    = lt_q;

  // next entry and occupancy
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.ins && !lt_q) begin
      if (left_i.lt) begin
        entry_d = ctrl_i.value;
        valid_d = 1'b1;
      end else begin
        entry_d = left_i.val;
        valid_d = left_i.valid;
      end
    end else if (ctrl_i.del && !lt_q) begin
      entry_d = right_i.val;
      valid_d = right_i.valid;
    end
  end

  // occupancy and compare flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmp) begin
        lt_q <= valid_q && (entry_q < ctrl_i.value);
        eq_q <= valid_q && (entry_q == ctrl_i.value);
      end
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/ste_ctrl.sv =====
// ----------------------------------------------------------------------------
// ste_ctrl
// Command sequencer: takes a request, steps the cell row through compare
// and update, keeps the count and builds the result request.
// ----------------------------------------------------------------------------
module ste_ctrl (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // command request
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             in_kind_i,
  input  logic signed [ste_pkg::VAL_W-1:0]       in_value_i,
  // result request
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   out_ok_o,
  output logic [ste_pkg::POS_W-1:0]              out_position_o,
  output logic [ste_pkg::COUNT_W-1:0]            out_count_o,
  output logic signed [ste_pkg::VAL_W-1:0]       out_smallest_o,
  output logic signed [ste_pkg::VAL_W-1:0]       out_largest_o,
  output logic                                   out_full_o,
  // cell row
  output ste_pkg::cell_ctrl_t                    cell_ctrl_o,
  input  logic [ste_pkg::CAPACITY-1:0]           first_ge_i,
  input  logic [ste_pkg::CAPACITY-1:0]           eq_i,
  input  logic [ste_pkg::CAPACITY-1:0][ste_pkg::VAL_W-1:0] last_val_i,
  input  ste_pkg::cell_nb_t                      head_i
);

  ste_pkg::state_e state_q, state_d;
  ste_pkg::kind_e  kind_q;
  logic signed [ste_pkg::VAL_W-1:0] value_q;
  logic [ste_pkg::CNT_W-1:0] count_q, count_d;
  logic ok_q, ok_d;
  logic [ste_pkg::IDX_W-1:0] pos_q, pos_d;
  logic [ste_pkg::IDX_W-1:0] ge_pos;
  logic found, full;
  logic [ste_pkg::VAL_W-1:0] largest;
  logic take, out_load;

  assign take     = in_valid_i && in_ready_o;
  assign found    = |eq_i;
  assign full     = (count_q == ste_pkg::CNT_W'(ste_pkg::CAPACITY));

  // one-hot to index of the first slot not below the value
  always_comb begin
    ge_pos = '0;
    for (int i = 0; i < ste_pkg::CAPACITY; i++) begin
      ge_pos = ge_pos | (first_ge_i[i] ? ste_pkg::IDX_W'(i) : '0);
    end
  end

  // or-tree over the masked last-slot values
  always_comb begin
    largest = '0;
    for (int i = 0; i < ste_pkg::CAPACITY; i++) begin
      largest = largest | last_val_i[i];
    end
  end

  // next state, cell strobes and result fields
  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    out_load          = 1'b0;
    count_d           = count_q;
    ok_d              = ok_q;
    pos_d             = pos_q;
    cell_ctrl_o.cmp   = 1'b0;
    cell_ctrl_o.ins   = 1'b0;
    cell_ctrl_o.del   = 1'b0;
    cell_ctrl_o.clr   = 1'b0;
    cell_ctrl_o.value = value_q;
    unique case (state_q)
      ste_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ste_pkg::ST_CMP;
        end
      end
      ste_pkg::ST_CMP: begin
        cell_ctrl_o.cmp = 1'b1;
        state_d         = ste_pkg::ST_UPD;
      end
      ste_pkg::ST_UPD: begin
        ok_d    = 1'b0;
        pos_d   = '0;
        state_d = ste_pkg::ST_RES;
        unique case (kind_q)
          ste_pkg::KIND_INSERT: begin
            if (!full) begin
              cell_ctrl_o.ins = 1'b1;
              ok_d            = 1'b1;
              pos_d           = ge_pos;
              count_d         = count_q + ste_pkg::CNT_W'(1);
            end
          end
          ste_pkg::KIND_DELETE: begin
            if (found) begin
              cell_ctrl_o.del = 1'b1;
              ok_d            = 1'b1;
              pos_d           = ge_pos;
              count_d         = count_q - ste_pkg::CNT_W'(1);
            end
          end
          ste_pkg::KIND_SEARCH: begin
            if (found) begin
              ok_d  = 1'b1;
              pos_d = ge_pos;
            end
          end
          ste_pkg::KIND_CLEAR: begin
            cell_ctrl_o.clr = 1'b1;
            ok_d            = 1'b1;
            count_d         = '0;
          end
          default: begin
          end
        endcase
      end
      ste_pkg::ST_RES: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ste_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ste_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ste_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // command capture and result payload
  always_ff @(posedge clk_i) begin
    ok_q  <= ok_d;
    pos_q <= pos_d;
    if (take) begin
      kind_q  <= ste_pkg::kind_e'(in_kind_i);
      value_q <= in_value_i;
    end
    if (out_load) begin
      out_ok_o       <= ok_q;
      out_position_o <= ste_pkg::POS_W'(pos_q);
      out_count_o    <= ste_pkg::COUNT_W'(count_q);
      out_smallest_o <= head_i.valid ? head_i.val : '0;
      out_largest_o  <= largest;
      out_full_o     <= full;
    end
  end

endmodule

// ===== rtl/sorted_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// sorted_table_engine_top
// Sorted table of signed values kept in a row of cells, with insert,
// delete, search and clear commands and one result per command.
// ----------------------------------------------------------------------------
// Each command steps through the cell row as take, compare, update and report;
// the result request is registered in the report step, which holds while an
// earlier result has not been taken, and a new command is taken only when idle.
// A new command is taken while the previous result still waits.
// Reset clears the count and the slot occupancy at once; entries themselves
// are not cleared and no clearing pass is run.
module sorted_table_engine_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ste_cmd_if.sink   cmd,
  ste_res_if.source res
);

  ste_pkg::cell_ctrl_t cell_ctrl;
  ste_pkg::cell_nb_t   nb [ste_pkg::CAPACITY];
  ste_pkg::cell_nb_t   left_edge, right_edge;
  logic [ste_pkg::CAPACITY-1:0] first_ge, eq;
  logic [ste_pkg::CAPACITY-1:0][ste_pkg::VAL_W-1:0] last_val;

  // row ends: everything lies above the head, nothing beyond the tail
  assign left_edge.val    = cell_ctrl.value;
  assign left_edge.valid  = 1'b0;
  assign left_edge.lt     = 1'b1;
  assign right_edge.val   = '0;
  assign right_edge.valid = 1'b0;
  assign right_edge.lt    = 1'b0;

  // cell row
  for (genvar i = 0; i < ste_pkg::CAPACITY; i++) begin : g_cell
    ste_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .left_i     ((i == 0) ? left_edge : nb[(i == 0) ? 0 : i - 1]),
      .right_i    ((i == ste_pkg::CAPACITY - 1) ? right_edge
                   : nb[(i == ste_pkg::CAPACITY - 1) ? i : i + 1]),
      .self_o     (nb[i]),
      .first_ge_o (first_ge[i]),
      .eq_o       (eq[i]),
      .last_val_o (last_val[i])
    );
  end

  // sequencer
  ste_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (cmd.valid),
    .in_ready_o     (cmd.ready),
    .in_kind_i      (cmd.kind),
    .in_value_i     (cmd.value),
    .out_valid_o    (res.valid),
    .out_ready_i    (res.ready),
    .out_ok_o       (res.ok),
    .out_position_o (res.position),
    .out_count_o    (res.count),
    .out_smallest_o (res.smallest),
    .out_largest_o  (res.largest),
    .out_full_o     (res.full_res),
    .cell_ctrl_o    (cell_ctrl),
    .first_ge_i     (first_ge),
    .eq_i           (eq),
    .last_val_i     (last_val),
    .head_i         (nb[0])
  );

endmodule
